FILE: rtl/core/ias_pkg.sv
// Package for the indexed array store: depth constants, command and status
// codes, and the sequencer state type. No dependencies.
package ias_pkg;
	localparam int Depth = 256;
	localparam int AW = $clog2(Depth);
	localparam int CW = AW + 1;

	typedef enum logic [3:0] {
		CMD_PUSH = 4'd0, CMD_INSERT = 4'd1, CMD_POP = 4'd2, CMD_REMOVE = 4'd3,
		CMD_READ = 4'd4, CMD_FIND = 4'd5, CMD_REMVAL = 4'd6, CMD_REVERSE = 4'd7,
		CMD_SORT = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_RANGE = 3'd2, ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS_WR, S_SH_RD, S_SH_WR, S_FIND_RD, S_FIND_CHK,
		S_REV_RD, S_REV_WR, S_SRT_KEY, S_SRT_RD, S_SRT_CMP, S_RD_WAIT, S_DONE
	} state_t;
endpackage

FILE: rtl/core/ias_if.sv
// Valid/ready channel interface for the indexed array store.
// Depends on nothing; payload width is given at instantiation.
interface ias_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/indexed_array_store_unit.sv
// Indexed array store: top level with the element memory and its sequencer.
// Depends on ias_pkg and ias_if.
//
// Usage: one command beat on "req" (data = {cmd[3:0], index[9:0], value[31:0]})
// produces exactly one result beat on "rsp" (data = {status[2:0],
// read_value[31:0], found_index[7:0], count[8:0]}). The block handles one
// command at a time: req.ready is high only while the sequencer is idle.
// Elements live in a single-port synchronous RAM with a registered read port,
// so the longer commands are walks of read and write steps over that RAM.
// Push, pop and checks that fail finish straight from idle; read at also waits
// for the RAM read; insert and remove take time in proportion to the moved
// elements, find to the elements scanned, reverse to the swapped pairs, and
// sort to its compare steps plus its keys (quadratic in count).
// The RAM port is what bounds all of these.
// Reset clears the element count and the sequencer; RAM contents are left
// undefined since only entries below the count are ever read.
// If the receiver stalls, the result is held in the output register and
// the next command waits until the result beat is taken.
module indexed_array_store_unit
	import ias_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ias_if.sink req,
	ias_if.source rsp
);
	logic [31:0] mem [Depth];
	logic [31:0] rdata_q;
	logic mwe;
	logic [AW-1:0] maddr;
	logic [31:0] mwdata;

	always_ff @(posedge clk) begin
		if (mwe)
			mem[maddr] <= mwdata;
		rdata_q <= mem[maddr];
	end

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d, lim_q, lim_d;
	logic [31:0] val_q, val_d, tmp_q, tmp_d;
	logic [3:0] cmd_q, cmd_d;
	status_t st_q, st_d;
	logic [31:0] rv_q, rv_d;
	logic [7:0] fi_q, fi_d;

	logic [3:0] c_cmd;
	logic signed [9:0] c_idx;
	logic [31:0] c_val;
	logic signed [10:0] npos;
	assign c_cmd = req.data[45:42];
	assign c_idx = req.data[41:32];
	assign c_val = req.data[31:0];
	assign npos = (c_idx < 0) ? 11'(c_idx) + 11'($signed({1'b0, count_q}))
		: 11'(c_idx);
	logic pos_ok;
	assign pos_ok = (npos >= 0) && (npos < 11'($signed({1'b0, count_q})));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_DONE);
	assign rsp.data = {st_q, rv_q, fi_q, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; j_q <= j_d; lim_q <= lim_d;
		val_q <= val_d; tmp_q <= tmp_d; cmd_q <= cmd_d;
		st_q <= st_d; rv_q <= rv_d; fi_q <= fi_d;
	end

	always_comb begin
		state_d = state_q; count_d = count_q;
		i_d = i_q; j_d = j_q; lim_d = lim_q; val_d = val_q; tmp_d = tmp_q;
		cmd_d = cmd_q; st_d = st_q; rv_d = rv_q; fi_d = fi_q;
		mwe = 1'b0; maddr = i_q[AW-1:0]; mwdata = val_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_d = c_cmd; val_d = c_val; st_d = ST_OK;
					rv_d = '0; fi_d = '0;
					state_d = S_DONE;
					if (c_cmd inside {[CMD_POP:CMD_SORT]} && count_q == '0) begin
						st_d = ST_EMPTY;
					end else begin
						case (c_cmd)
							CMD_PUSH: begin
								if (count_q == CW'(Depth)) st_d = ST_FULL;
								else begin
									mwe = 1'b1; maddr = count_q[AW-1:0];
									mwdata = c_val; count_d = count_q + 1'b1;
								end
							end
							CMD_INSERT: begin
								if (c_idx < 0 || 11'(c_idx) > 11'({1'b0, count_q}))
									st_d = ST_RANGE;
								else if (count_q == CW'(Depth)) st_d = ST_FULL;
								else begin
									i_d = count_q; lim_d = CW'(c_idx[8:0]);
									state_d = S_INS_RD;
								end
							end
							CMD_POP: count_d = count_q - 1'b1;
							CMD_REMOVE: begin
								if (!pos_ok) st_d = ST_RANGE;
								else begin
									i_d = CW'(npos[8:0]); state_d = S_SH_RD;
								end
							end
							CMD_READ: begin
								if (!pos_ok) st_d = ST_RANGE;
								else begin
									maddr = npos[AW-1:0]; state_d = S_RD_WAIT;
								end
							end
							CMD_FIND, CMD_REMVAL: begin
								i_d = '0; state_d = S_FIND_RD;
							end
							CMD_REVERSE: begin
								i_d = '0; j_d = count_q - 1'b1; state_d = S_REV_RD;
							end
							CMD_SORT: begin
								i_d = CW'(1); state_d = S_SRT_KEY;
							end
							default: ;
						endcase
					end
				end
			end
			S_RD_WAIT: begin
				rv_d = rdata_q; state_d = S_DONE;
			end
			// Insert: move entries up from the top down to the slot.
			S_INS_RD: begin
				if (i_q == lim_q) begin
					mwe = 1'b1; maddr = lim_q[AW-1:0]; mwdata = val_q;
					count_d = count_q + 1'b1; state_d = S_DONE;
				end else begin
					maddr = AW'(i_q - 1'b1); state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				mwe = 1'b1; maddr = i_q[AW-1:0]; mwdata = rdata_q;
				i_d = i_q - 1'b1; state_d = S_INS_RD;
			end
			// Remove: move entries down from the slot to the top.
			S_SH_RD: begin
				if (i_q + 1'b1 >= count_q) begin
					count_d = count_q - 1'b1; state_d = S_DONE;
				end else begin
					maddr = AW'(i_q + 1'b1); state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				mwe = 1'b1; maddr = i_q[AW-1:0]; mwdata = rdata_q;
				i_d = i_q + 1'b1; state_d = S_SH_RD;
			end
			S_FIND_RD: begin
				if (i_q >= count_q) begin
					st_d = ST_NOTFOUND; state_d = S_DONE;
				end else begin
					state_d = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if (rdata_q == val_q) begin
					fi_d = i_q[7:0];
					state_d = (cmd_q == CMD_REMVAL) ? S_SH_RD : S_DONE;
				end else begin
					i_d = i_q + 1'b1; state_d = S_FIND_RD;
				end
			end
			// Reverse: read both ends, then write them crossed.
			S_REV_RD: begin
				if (i_q >= j_q || j_q[CW-1]) state_d = S_DONE;
				else begin
					state_d = S_REV_WR; lim_d = '0;
				end
			end
			S_REV_WR: begin
				case (lim_q[1:0])
					2'd0: begin
						maddr = j_q[AW-1:0]; tmp_d = rdata_q; lim_d = CW'(1);
					end
					2'd1: begin
						mwe = 1'b1; maddr = i_q[AW-1:0]; mwdata = rdata_q;
						lim_d = CW'(2);
					end
					default: begin
						mwe = 1'b1; maddr = j_q[AW-1:0]; mwdata = tmp_q;
						i_d = i_q + 1'b1; j_d = j_q - 1'b1; state_d = S_REV_RD;
					end
				endcase
			end
			// Sort: i is the key position, j walks down the sorted prefix.
			S_SRT_KEY: begin
				if (i_q >= count_q) state_d = S_DONE;
				else begin
					j_d = i_q; lim_d = '0; state_d = S_SRT_RD;
				end
			end
			S_SRT_RD: begin
				if (lim_q == '0) begin
					lim_d = CW'(1); state_d = S_SRT_RD;
				end else if (lim_q == CW'(1)) begin
					val_d = rdata_q; lim_d = CW'(2);
					if (j_q == '0) state_d = S_SRT_CMP;
					else maddr = AW'(j_q - 1'b1);
				end else begin
					state_d = S_SRT_CMP;
					maddr = AW'(j_q - 1'b1);
				end
			end
			S_SRT_CMP: begin
				if (j_q != '0 && $signed(rdata_q) > $signed(val_q)) begin
					mwe = 1'b1; maddr = j_q[AW-1:0]; mwdata = rdata_q;
					j_d = j_q - 1'b1; lim_d = CW'(3); state_d = S_SRT_RD;
				end else begin
					mwe = 1'b1; maddr = j_q[AW-1:0]; mwdata = val_q;
					i_d = i_q + 1'b1; state_d = S_SRT_KEY;
				end
			end
			S_DONE: begin
				if (rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// Reverse read phase issues the low-end read on entry; find and the sort key read also address the RAM from i.
		if (state_q == S_REV_RD) maddr = i_q[AW-1:0];
		if (state_q == S_FIND_RD) maddr = i_q[AW-1:0];
		if (state_q == S_SRT_RD && lim_q == '0) maddr = i_q[AW-1:0];
	end
endmodule

FILE: rtl/core/ias_checker.sv
// Port-level checker for the indexed array store, bound to the top level.
// Depends on ias_if through the bound ports.
module ias_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [8:0] rsp_count
);
	// One command in flight: no new command while a result is shown.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("ready while result pending");
	// An accepted command drops ready, so no second command is taken straight behind it.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("second accept");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
		else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_count <= 9'd256) else $error("count over depth");
endmodule

bind indexed_array_store_unit ias_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_count(rsp.data[8:0])
);

FILE: bench/tb_top.sv
// Self-checking bench for indexed_array_store_unit: a shadow copy of the element store
// predicts every result beat, and the bench varies stalls on both handshakes.
// Depends on ias_pkg, ias_if and the block itself.
module tb_top;
	import ias_pkg::*;

	// Result beat layout, most significant field first, as the block packs it.
	typedef struct packed {
		status_t st;
		logic [31:0] rd;
		logic [7:0] fi;
		logic [8:0] cnt;
	} result_t;

	// Shadow copy of the store. A command is applied to it when its beat is accepted.
	// The result that the command should give is queued in arrival order.
	class array_store_checker;
		logic [31:0] mem [Depth];
		int elem_count;
		result_t owed [$];
		int mismatches;

		function new();
			elem_count = 0;
			mismatches = 0;
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		endtask

		function void note_command(logic [3:0] cmd, logic signed [9:0] idx, logic [31:0] val);
			result_t r;
			int p;
			int i;
			int j;
			logic [31:0] key;
			logic [31:0] t;
			r = '0;
			r.st = ST_OK;
			p = idx;
			if (cmd != CMD_PUSH && cmd != CMD_INSERT && cmd <= CMD_SORT && elem_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				case (cmd)
					CMD_PUSH: begin
						if (elem_count >= Depth) begin
							r.st = ST_FULL;
						end else begin
							mem[elem_count] = val;
							elem_count++;
						end
					end
					CMD_INSERT: begin
						if (p < 0 || p > elem_count) begin
							r.st = ST_RANGE;
						end else if (elem_count >= Depth) begin
							r.st = ST_FULL;
						end else begin
							for (i = elem_count; i > p; i--)
								mem[i] = mem[i-1];
							mem[p] = val;
							elem_count++;
						end
					end
					CMD_POP: elem_count--;
					CMD_REMOVE, CMD_READ: begin
						if (p < 0)
							p += elem_count;
						if (p < 0 || p >= elem_count) begin
							r.st = ST_RANGE;
						end else if (cmd == CMD_READ) begin
							r.rd = mem[p];
						end else begin
							for (i = p; i + 1 < elem_count; i++)
								mem[i] = mem[i+1];
							elem_count--;
						end
					end
					CMD_FIND, CMD_REMVAL: begin
						p = -1;
						for (i = 0; i < elem_count && p < 0; i++)
							if (mem[i] == val)
								p = i;
						if (p < 0) begin
							r.st = ST_NOTFOUND;
						end else begin
							r.fi = p[7:0];
							if (cmd == CMD_REMVAL) begin
								for (i = p; i + 1 < elem_count; i++)
									mem[i] = mem[i+1];
								elem_count--;
							end
						end
					end
					CMD_REVERSE: begin
						for (i = 0; i < elem_count / 2; i++) begin
							j = elem_count - 1 - i;
							t = mem[i];
							mem[i] = mem[j];
							mem[j] = t;
						end
					end
					CMD_SORT: begin
						// Stable: an element only moves past strictly greater ones.
						for (i = 1; i < elem_count; i++) begin
							key = mem[i];
							j = i;
							while (j > 0 && $signed(mem[j-1]) > $signed(key)) begin
								mem[j] = mem[j-1];
								j--;
							end
							mem[j] = key;
						end
					end
					default: ;
				endcase
			end
			r.cnt = elem_count[8:0];
			owed.push_back(r);
		endfunction

		task check_result(logic [51:0] beat);
			result_t got;
			result_t want;
			got = beat;
			if (owed.size() == 0) begin
				report("result with nothing owed", beat, 0);
			end else begin
				want = owed.pop_front();
				if (got.st != want.st) report("status", got.st, want.st);
				if (got.rd != want.rd) report("read_value", got.rd, want.rd);
				if (got.fi != want.fi) report("found_index", got.fi, want.fi);
				if (got.cnt != want.cnt) report("count", got.cnt, want.cnt);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	ias_if #(46) req_if ();
	ias_if #(52) rsp_if ();

	indexed_array_store_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	array_store_checker sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested so that
	// the block fills up with a finished result and must refuse new commands.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result beat is checked against the oldest owed result.
	always @(posedge clk)
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.data);

	// Offers one command beat and notes it in the shadow store once accepted.
	// The valid line stays high from one beat to the next unless the sender idles.
	task send_command(logic [3:0] cmd, logic signed [9:0] idx, logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= {cmd, idx, val};
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_command(cmd, idx, val);
	endtask

	// Values are drawn so that find and remove usually hit, and a small pool makes
	// duplicates common for the first-match and stable-sort cases.
	function logic [31:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40 && sb.elem_count > 0)
			return sb.mem[$urandom_range(sb.elem_count - 1)];
		else if (roll < 70)
			return 32'($signed($urandom_range(8)) - 4);
		else if (roll < 75)
			return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
		return $urandom;
	endfunction

	// Mostly a position near the live range, either sign; sometimes anywhere.
	function logic signed [9:0] pick_index();
		int n;
		n = sb.elem_count;
		if ($urandom_range(99) < 75)
			return 10'($signed($urandom_range(2 * n + 2)) - n - 1);
		return 10'($signed($urandom_range(512)) - 256);
	endfunction

	task send_random();
		int roll;
		logic [3:0] cmd;
		roll = $urandom_range(99);
		if (roll < 25) cmd = CMD_PUSH;
		else if (roll < 40) cmd = CMD_INSERT;
		else if (roll < 48) cmd = CMD_POP;
		else if (roll < 58) cmd = CMD_REMOVE;
		else if (roll < 72) cmd = CMD_READ;
		else if (roll < 80) cmd = CMD_FIND;
		else if (roll < 87) cmd = CMD_REMVAL;
		else if (roll < 92) cmd = CMD_REVERSE;
		else if (roll < 98) cmd = CMD_SORT;
		else cmd = 4'($urandom_range(15, 9));
		// Keep the store small so that sorts and shifts stay short.
		if ((cmd == CMD_PUSH || cmd == CMD_INSERT) && sb.elem_count > 40 && $urandom_range(1))
			cmd = CMD_POP;
		if (cmd == CMD_SORT && sb.elem_count > 48)
			cmd = CMD_READ;
		send_command(cmd, pick_index(), pick_value());
	endtask

	initial begin
		int ph;
		int k;
		int wait_cycles;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every command but push on an empty store, then the edges of the ranges.
		send_command(CMD_POP, 0, 0);
		send_command(CMD_REMOVE, 0, 0);
		send_command(CMD_READ, -1, 0);
		send_command(CMD_FIND, 0, 0);
		send_command(CMD_REMVAL, 0, 0);
		send_command(CMD_REVERSE, 0, 0);
		send_command(CMD_SORT, 0, 0);
		send_command(CMD_INSERT, 1, 32'd9);
		send_command(CMD_INSERT, -1, 32'd9);
		send_command(CMD_INSERT, 0, 32'h8000_0000);
		send_command(CMD_PUSH, 0, 32'h7fff_ffff);
		send_command(CMD_PUSH, 0, 32'hffff_ffff);
		send_command(CMD_PUSH, 0, 32'hffff_ffff);
		send_command(CMD_INSERT, 4, 32'd5);
		send_command(CMD_READ, -1, 0);
		send_command(CMD_READ, -6, 0);
		send_command(CMD_READ, 5, 0);
		send_command(CMD_FIND, 0, 32'hffff_ffff);
		send_command(CMD_REMVAL, 0, 32'd5);
		send_command(CMD_FIND, 0, 32'd12345);
		send_command(CMD_SORT, 0, 0);
		send_command(CMD_REVERSE, 0, 0);
		send_command(CMD_REMOVE, -1, 0);
		send_command(CMD_REMOVE, 0, 0);
		send_command(4'd9, 10'sd255, 32'd1);
		send_command(4'd15, -10'sd256, 32'd1);

		// Random phases with different idling on each side.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			if (ph == 0)
				hold_request = 300;
			for (k = 0; k < 310; k++)
				send_random();
		end

		// Fill the store to capacity, push and insert against the full store, then drain it to eight entries.
		send_idle_pct = 11;
		recv_stall_pct = 11;
		while (sb.elem_count < Depth)
			if ($urandom_range(3) == 0)
				send_command(CMD_INSERT, 10'($urandom_range(sb.elem_count)), pick_value());
			else
				send_command(CMD_PUSH, 0, pick_value());
		send_command(CMD_PUSH, 0, 32'd1);
		send_command(CMD_INSERT, 10'sd256, 32'd1);
		send_command(CMD_INSERT, 0, 32'd1);
		send_command(CMD_READ, -10'sd256, 0);
		send_command(CMD_READ, 10'sd255, 0);
		send_command(CMD_FIND, 0, sb.mem[Depth-1]);
		send_command(CMD_REVERSE, 0, 0);
		while (sb.elem_count > 8)
			case ($urandom_range(3))
				0: send_command(CMD_REMOVE, pick_index(), 0);
				1: send_command(CMD_REMVAL, 0, pick_value());
				default: send_command(CMD_POP, 0, 0);
			endcase
		for (k = 0; k < 120; k++)
			send_random();
		req_if.valid <= 1'b0;

		// Drain the owed results, then keep watching for stray beats.
		wait_cycles = 0;
		while (sb.owed.size() > 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run with every stall at its longest.
	initial begin
		#72000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
